// ===== src/bfe_pkg.sv =====
// bfe_pkg: shared constants, types and helpers of the brainfuck execution unit
// used by the channel interfaces, the top level and the checker

package bfe_pkg;

  localparam int TAPE_DEPTH  = 32768;
  localparam int STACK_DEPTH = 256;
  localparam int CODE_DEPTH  = 65536;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = 16;
  localparam int CFG_W  = 16;
  localparam int SKIP_W = 16;
  localparam int PTR_W  = $clog2(TAPE_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [CFG_W-1:0] TAPE_CELLS_RESET = CFG_W'(32768);

  localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_INC   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DEC   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PRINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_READ  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_DONE    = 3'd1,
    ST_RIGHT   = 3'd2,
    ST_LEFT    = 3'd3,
    ST_OVER    = 3'd4,
    ST_UNDER   = 3'd5,
    ST_SKIPEND = 3'd6
  } status_t;

  function automatic logic [ADDR_W-1:0] step_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W+1)'(1);
    return ADDR_W'(s % CODE_DEPTH);
  endfunction

endpackage

// ===== src/bfe_ifs.sv =====
// bfe_ifs: valid/ready channel interfaces of the brainfuck execution unit
// depends on bfe_pkg for field widths and the status type

interface bfe_in_if import bfe_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   instr;
  logic [ADDR_W-1:0]   instr_addr;
  logic [CHAR_W-1:0]   in_byte;
  logic                new_run;

  modport source (output valid, instr, instr_addr, in_byte, new_run, input ready);
  modport sink   (input valid, instr, instr_addr, in_byte, new_run, output ready);
endinterface

interface bfe_out_if import bfe_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   next_addr;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_byte;
  logic                in_taken;
  status_t             status;

  modport source (output valid, next_addr, out_valid, out_byte, in_taken, status,
                  input ready);
  modport sink   (input valid, next_addr, out_valid, out_byte, in_taken, status,
                  output ready);
endinterface

interface bfe_cfg_if import bfe_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CFG_W-1:0]   tape_cells;

  modport source (output valid, tape_cells, input ready);
  modport sink   (input valid, tape_cells, output ready);
endinterface

// ===== src/bfe_ram.sv =====
// bfe_ram: generic single-write, single-read ram with registered read data
// no dependencies

module bfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/brainfuck_execution_unit_top.sv =====
// brainfuck_execution_unit_top: executes one program character per item
// depends on bfe_pkg, bfe_ifs and bfe_ram (tape and loop stack)
//
// Channels: in_ch carries one program character with its address, the byte
// for ',' and a new_run flag; out_ch returns one result per item (next fetch
// address, printed byte, input-taken flag, status); cfg_ch writes tape_cells
// and is always ready.
// Throughput: one item per cycle sustained while out_ch.ready is high. An
// item accepted at one edge is executed in the following cycle, when its
// tape cell and top stack entry come out of the rams, and its result is
// registered. The loop that sets the rate is the tape read-modify-write:
// the next item's read address is formed from the executing item's result
// in the same cycle, and a write to the same cell is forwarded.
// Reset: synchronous, active low. After reset the tape is cleared by a pass
// over all 32768 cells, one cell a cycle, during which in_ch.ready is low.
// Stall: while out_ch.ready is low a waiting result holds; one more item can
// sit in execution, after which in_ch.ready drops until the result is taken.

module brainfuck_execution_unit_top import bfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bfe_in_if.sink     in_ch,
  bfe_out_if.source  out_ch,
  bfe_cfg_if.sink    cfg_ch
);

  logic [CFG_W-1:0]  tape_cells_r;
  logic              clr_active_r;
  logic [PTR_W-1:0]  clr_addr_r;

  logic [PTR_W-1:0]  ptr_r, ptr_nxt, ptr0, ptr_after;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt0, cnt_after;
  logic [SKIP_W-1:0] skip_r, skip_nxt, skip0;
  status_t           st_r, st_nxt, st0;

  logic              ex_valid_r;
  logic [CHAR_W-1:0] ex_instr_r;
  logic [ADDR_W-1:0] ex_addr_r;
  logic [CHAR_W-1:0] ex_inb_r;
  logic              ex_new_run_r;

  logic              out_vld_r;
  logic [ADDR_W-1:0] out_next_r;
  logic              out_print_r;
  logic [CHAR_W-1:0] out_byte_r;
  logic              out_taken_r;
  status_t           out_st_r;

  logic              in_acc, ex_fire;

  logic              tape_we;
  logic [PTR_W-1:0]  tape_waddr, tape_raddr;
  logic [CHAR_W-1:0] tape_wdata, tape_rdata;
  logic              tape_fwd_r;
  logic [CHAR_W-1:0] tape_fwd_data_r;

  logic              stack_we;
  logic [SP_W-1:0]   stack_waddr, stack_raddr;
  logic [ADDR_W-1:0] stack_rdata;
  logic              stack_fwd_r;
  logic [ADDR_W-1:0] stack_fwd_data_r;

  logic [CHAR_W-1:0] cell_val;
  logic [ADDR_W-1:0] stack_top;
  logic [CFG_W:0]    lim, ptr_inc;

  logic              x_tape_we;
  logic [CHAR_W-1:0] x_tape_wdata;
  logic              x_stack_we;
  logic [ADDR_W-1:0] res_next;
  logic              res_print;
  logic [CHAR_W-1:0] res_byte;
  logic              res_taken;

  // configuration and tape clearing pass
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_cells_r <= TAPE_CELLS_RESET;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_ch.valid) begin
        tape_cells_r <= cfg_ch.tape_cells;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + PTR_W'(1);
        if (clr_addr_r == PTR_W'(TAPE_DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  // handshakes
  assign ex_fire      = ex_valid_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !clr_active_r && (!ex_valid_r || ex_fire);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // state as the executing item leaves it, and the read addresses of a new item
  assign ptr_after   = ex_fire ? ptr_nxt : ptr_r;
  assign cnt_after   = ex_fire ? cnt_nxt : cnt_r;
  assign tape_raddr  = in_ch.new_run ? '0 : ptr_after;
  assign stack_raddr = in_ch.new_run ? SP_W'(CNT_W'(0) - CNT_W'(1))
                                     : SP_W'(cnt_after - CNT_W'(1));

  assign lim = (tape_cells_r == '0) ? (CFG_W+1)'(1) :
               ((CFG_W+1)'(tape_cells_r) > (CFG_W+1)'(TAPE_DEPTH)) ?
               (CFG_W+1)'(TAPE_DEPTH) : (CFG_W+1)'(tape_cells_r);

  assign cell_val  = tape_fwd_r  ? tape_fwd_data_r  : tape_rdata;
  assign stack_top = stack_fwd_r ? stack_fwd_data_r : stack_rdata;

  // execute
  always_comb begin
    ptr0         = ex_new_run_r ? '0 : ptr_r;
    cnt0         = ex_new_run_r ? '0 : cnt_r;
    skip0        = ex_new_run_r ? '0 : skip_r;
    st0          = ex_new_run_r ? ST_RUN : st_r;
    ptr_inc      = (CFG_W+1)'(ptr0) + (CFG_W+1)'(1);
    ptr_nxt      = ptr0;
    cnt_nxt      = cnt0;
    skip_nxt     = skip0;
    st_nxt       = st0;
    res_next     = step_addr(ex_addr_r);
    res_print    = 1'b0;
    res_byte     = '0;
    res_taken    = 1'b0;
    x_tape_we    = 1'b0;
    x_tape_wdata = cell_val;
    x_stack_we   = 1'b0;
    if (st0 != ST_RUN) begin
      res_next = ex_addr_r;
    end else if (skip0 != '0) begin
      if (ex_instr_r == CH_END) begin
        st_nxt   = ST_SKIPEND;
        res_next = ex_addr_r;
      end else if (ex_instr_r == CH_OPEN) begin
        if (skip0 != '1) begin
          skip_nxt = skip0 + SKIP_W'(1);
        end
      end else if (ex_instr_r == CH_CLOSE) begin
        skip_nxt = skip0 - SKIP_W'(1);
      end
    end else begin
      unique case (ex_instr_r)
        CH_END: begin
          st_nxt   = ST_DONE;
          res_next = ex_addr_r;
        end
        CH_RIGHT: begin
          if (ptr_inc >= lim) begin
            st_nxt   = ST_RIGHT;
            res_next = ex_addr_r;
          end else begin
            ptr_nxt = ptr0 + PTR_W'(1);
          end
        end
        CH_LEFT: begin
          if (ptr0 == '0) begin
            st_nxt   = ST_LEFT;
            res_next = ex_addr_r;
          end else begin
            ptr_nxt = ptr0 - PTR_W'(1);
          end
        end
        CH_INC: begin
          x_tape_we    = 1'b1;
          x_tape_wdata = cell_val + CHAR_W'(1);
        end
        CH_DEC: begin
          x_tape_we    = 1'b1;
          x_tape_wdata = cell_val - CHAR_W'(1);
        end
        CH_PRINT: begin
          res_print = 1'b1;
          res_byte  = cell_val;
        end
        CH_READ: begin
          x_tape_we    = 1'b1;
          x_tape_wdata = ex_inb_r;
          res_taken    = 1'b1;
        end
        CH_OPEN: begin
          if (cell_val == '0) begin
            skip_nxt = SKIP_W'(1);
          end else if (cnt0 >= CNT_W'(STACK_DEPTH)) begin
            st_nxt   = ST_OVER;
            res_next = ex_addr_r;
          end else begin
            x_stack_we = 1'b1;
            cnt_nxt    = cnt0 + CNT_W'(1);
          end
        end
        CH_CLOSE: begin
          if (cnt0 == '0) begin
            st_nxt   = ST_UNDER;
            res_next = ex_addr_r;
          end else if (cell_val != '0) begin
            res_next = step_addr(stack_top);
          end else begin
            cnt_nxt = cnt0 - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ram ports
  assign tape_we     = clr_active_r || (ex_fire && x_tape_we);
  assign tape_waddr  = clr_active_r ? clr_addr_r : ptr0;
  assign tape_wdata  = clr_active_r ? '0 : x_tape_wdata;
  assign stack_we    = ex_fire && x_stack_we;
  assign stack_waddr = SP_W'(cnt0);

  bfe_ram #(.WIDTH(CHAR_W), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (in_acc),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  bfe_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (ex_addr_r),
    .re    (in_acc),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // control state, execute stage and forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      cnt_r      <= '0;
      skip_r     <= '0;
      st_r       <= ST_RUN;
      ex_valid_r <= 1'b0;
    end else begin
      if (ex_fire) begin
        ptr_r  <= ptr_nxt;
        cnt_r  <= cnt_nxt;
        skip_r <= skip_nxt;
        st_r   <= st_nxt;
      end
      if (in_acc) begin
        ex_valid_r <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_instr_r       <= in_ch.instr;
      ex_addr_r        <= in_ch.instr_addr;
      ex_inb_r         <= in_ch.in_byte;
      ex_new_run_r     <= in_ch.new_run;
      tape_fwd_r       <= ex_fire && x_tape_we && (ptr0 == tape_raddr);
      tape_fwd_data_r  <= x_tape_wdata;
      stack_fwd_r      <= stack_we && (stack_waddr == stack_raddr);
      stack_fwd_data_r <= ex_addr_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ex_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_next_r  <= res_next;
      out_print_r <= res_print;
      out_byte_r  <= res_byte;
      out_taken_r <= res_taken;
      out_st_r    <= st_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.next_addr = out_next_r;
  assign out_ch.out_valid = out_print_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.in_taken  = out_taken_r;
  assign out_ch.status    = out_st_r;

endmodule

// ===== src/bfe_checker.sv =====
// bfe_checker: port-level assertions for brainfuck_execution_unit_top
// depends on bfe_pkg; bound to the top level at the end of this file

module bfe_checker import bfe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_next_addr,
  input logic              out_print,
  input logic [CHAR_W-1:0] out_byte,
  input logic              out_in_taken,
  input logic [2:0]        out_status
);

  // no item taken while the tape is being cleared after reset
  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_addr)
      && $stable(out_print) && $stable(out_byte) && $stable(out_in_taken)
      && $stable(out_status))
    else $error("stalled result changed");

  // printing or reading only happens on a running item
  a_io_only_when_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_print || out_in_taken) |->
      out_status == 3'(ST_RUN) && !(out_print && out_in_taken))
    else $error("io flag on a halted item");

endmodule

bind brainfuck_execution_unit_top bfe_checker u_bfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_next_addr (out_ch.next_addr),
  .out_print     (out_ch.out_valid),
  .out_byte      (out_ch.out_byte),
  .out_in_taken  (out_ch.in_taken),
  .out_status    (out_ch.status)
);

// ===== sim/bfe_exec_checker.sv =====
// bfe_exec_checker: watches the item, result and tape_cells channels of the execution unit,
// predicts every result from its own tape, pointer, loop stack and skip counter, and compares
// depends on bfe_pkg for widths, character codes and the status type, and on bfe_ifs
`timescale 1ns / 1ps

module bfe_exec_checker import bfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bfe_in_if    in_mon,
  bfe_out_if   out_mon,
  bfe_cfg_if   cfg_mon,
  output int   mismatch_count,
  output int   results_owed
);

  typedef struct {
    logic [ADDR_W-1:0] next_addr;
    logic              out_valid;
    logic [CHAR_W-1:0] out_byte;
    logic              in_taken;
    status_t           status;
  } bf_result_t;

  logic [CHAR_W-1:0] tape [TAPE_DEPTH];
  logic [ADDR_W-1:0] loop_addr [STACK_DEPTH];
  int                cell_ptr;
  int                loop_depth;
  int                skip_nest;
  status_t           run_state;
  logic [CFG_W-1:0]  cells_cfg;
  bf_result_t        owed_results [$];
  int                errs = 0;

  function automatic logic [ADDR_W-1:0] addr_after(input logic [ADDR_W-1:0] a);
    return ADDR_W'((int'(a) + 1) % CODE_DEPTH);
  endfunction

  function automatic bf_result_t run_instruction(input logic [CHAR_W-1:0] ch,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [CHAR_W-1:0] inb,
                                                 input logic              fresh);
    bf_result_t r;
    int         p;
    int         lim;
    r.next_addr = addr_after(addr);
    r.out_valid = 1'b0;
    r.out_byte  = '0;
    r.in_taken  = 1'b0;
    if (fresh) begin
      cell_ptr   = 0;
      loop_depth = 0;
      skip_nest  = 0;
      run_state  = ST_RUN;
    end
    p = (cell_ptr >= TAPE_DEPTH) ? 0 : cell_ptr;
    lim = int'(cells_cfg);
    if (lim == 0) lim = 1;
    if (lim > TAPE_DEPTH) lim = TAPE_DEPTH;

    if (run_state != ST_RUN) begin
      r.next_addr = addr;
    end else if (skip_nest > 0) begin
      if (ch == CH_END) begin
        run_state   = ST_SKIPEND;
        r.next_addr = addr;
      end else if (ch == CH_OPEN) begin
        if (skip_nest < 65535) skip_nest++;
      end else if (ch == CH_CLOSE) begin
        skip_nest--;
      end
    end else begin
      case (ch)
        CH_END: begin
          run_state   = ST_DONE;
          r.next_addr = addr;
        end
        CH_RIGHT: begin
          if (p + 1 >= lim) begin
            run_state   = ST_RIGHT;
            r.next_addr = addr;
          end else begin
            cell_ptr = p + 1;
          end
        end
        CH_LEFT: begin
          if (p == 0) begin
            run_state   = ST_LEFT;
            r.next_addr = addr;
          end else begin
            cell_ptr = p - 1;
          end
        end
        CH_INC: tape[p] = tape[p] + 1'b1;
        CH_DEC: tape[p] = tape[p] - 1'b1;
        CH_PRINT: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape[p];
        end
        CH_READ: begin
          tape[p]    = inb;
          r.in_taken = 1'b1;
        end
        CH_OPEN: begin
          if (tape[p] == '0) begin
            skip_nest = 1;
          end else if (loop_depth >= STACK_DEPTH) begin
            run_state   = ST_OVER;
            r.next_addr = addr;
          end else begin
            loop_addr[loop_depth] = addr;
            loop_depth++;
          end
        end
        CH_CLOSE: begin
          if (loop_depth == 0) begin
            run_state   = ST_UNDER;
            r.next_addr = addr;
          end else if (tape[p] != '0) begin
            r.next_addr = addr_after(loop_addr[loop_depth-1]);
          end else begin
            loop_depth--;
          end
        end
        default: ;
      endcase
    end
    r.status = run_state;
    return r;
  endfunction

  function automatic void field_check(input string name, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    bf_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TAPE_DEPTH; i++) tape[i] = '0;
      cell_ptr   = 0;
      loop_depth = 0;
      skip_nest  = 0;
      run_state  = ST_RUN;
      cells_cfg  = TAPE_CELLS_RESET;
      owed_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) cells_cfg = cfg_mon.tape_cells;
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result with no item waiting: next_addr %0h", out_mon.next_addr);
          errs++;
        end else begin
          want = owed_results.pop_front();
          field_check("next_addr", want.next_addr, out_mon.next_addr);
          field_check("out_valid", want.out_valid, out_mon.out_valid);
          field_check("out_byte", want.out_byte, out_mon.out_byte);
          field_check("in_taken", want.in_taken, out_mon.in_taken);
          field_check("status", want.status, out_mon.status);
        end
      end
      if (in_mon.valid && in_mon.ready)
        owed_results.push_back(run_instruction(in_mon.instr, in_mon.instr_addr,
                                               in_mon.in_byte, in_mon.new_run));
    end
    mismatch_count <= errs;
    results_owed   <= owed_results.size();
  end

endmodule

// ===== sim/brainfuck_execution_unit_top_tb.sv =====
// brainfuck_execution_unit_top_tb: clock, reset, program-character stimulus, tape_cells writes
// and result-side back-pressure for the execution unit; bfe_exec_checker judges every result
// depends on bfe_pkg, bfe_ifs, brainfuck_execution_unit_top and bfe_exec_checker
`timescale 1ns / 1ps

module brainfuck_execution_unit_top_tb;
  import bfe_pkg::*;

  localparam int CYCLE_LIMIT    = 4000000;
  localparam int HOLD_AT_RESULT = 1200;
  localparam int HOLD_CYCLES    = 400;

  logic clk;
  logic rst_n;
  int   send_idle_pct = 27;
  int   recv_idle_pct = 75;
  int   items_sent = 0;
  int   mismatch_count;
  int   results_owed;
  logic [ADDR_W-1:0] pc;

  bfe_in_if  in_ch ();
  bfe_out_if out_ch ();
  bfe_cfg_if cfg_ch ();

  brainfuck_execution_unit_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bfe_exec_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic issue(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] inb,
                       input logic fresh);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.instr      <= ch;
    in_ch.instr_addr <= pc;
    in_ch.in_byte    <= inb;
    in_ch.new_run    <= fresh;
    pc = pc + 1'b1;
    items_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic set_tape_cells(input logic [CFG_W-1:0] cells);
    wait_idle();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.tape_cells <= cells;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly bracket-balanced programs that start a new run, some loop-stack floods,
  // some pure noise with random addresses and new_run
  task automatic run_random(input int n_items);
    int target;
    int kind;
    int len;
    int nest;
    int offset;
    int r;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] inb;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      pc = ADDR_W'($urandom);
      if (kind < 10) begin
        len = $urandom_range(3, 20);
        repeat (len) begin
          pc = ADDR_W'($urandom);
          issue(CHAR_W'($urandom), CHAR_W'($urandom), $urandom_range(0, 7) == 0);
        end
      end else if (kind < 13) begin
        issue(CH_READ, CHAR_W'($urandom_range(1, 255)), 1'b1);
        repeat (STACK_DEPTH + 1) issue(CH_OPEN, '0, 1'b0);
      end else begin
        len = $urandom_range(8, 60);
        nest = 0;
        offset = 0;
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          inb = CHAR_W'($urandom);
          if (r < 14) ch = CH_INC;
          else if (r < 20) ch = CH_DEC;
          else if (r < 32) ch = CH_RIGHT;
          else if (r < 42) ch = (offset > 0) ? CH_LEFT : CH_RIGHT;
          else if (r < 52) ch = CH_PRINT;
          else if (r < 62) begin
            ch = CH_READ;
            if ($urandom_range(0, 4) == 0) inb = '0;
          end else if (r < 76) ch = (nest < 20) ? CH_OPEN : CH_INC;
          else if (r < 90) ch = (nest > 0) ? CH_CLOSE : CH_PRINT;
          else if (r < 98) begin
            ch = CHAR_W'($urandom);
            if (ch inside {CH_END, CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_PRINT, CH_READ,
                           CH_OPEN, CH_CLOSE})
              ch = 8'h20;
          end else ch = CH_END;
          if (ch == CH_RIGHT) offset++;
          if (ch == CH_LEFT) offset--;
          if (ch == CH_OPEN) nest++;
          if (ch == CH_CLOSE) nest--;
          issue(ch, inb, i == 0);
        end
        while (nest > 0) begin
          issue(CH_CLOSE, CHAR_W'($urandom), 1'b0);
          nest--;
        end
        if ($urandom_range(0, 1) == 1) issue(CH_END, CHAR_W'($urandom), 1'b0);
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (!held && taken >= HOLD_AT_RESULT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.instr       <= '0;
    in_ch.instr_addr  <= '0;
    in_ch.in_byte     <= '0;
    in_ch.new_run     <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.tape_cells <= TAPE_CELLS_RESET;
    pc = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every command, wrap of cell values, halts and their hold, skips
    issue(CH_PRINT, 8'h00, 1'b1);
    issue(CH_INC, 8'h00, 1'b0);
    issue(CH_DEC, 8'h00, 1'b0);
    issue(CH_DEC, 8'h00, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_READ, 8'hA5, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_LEFT, 8'h00, 1'b0);
    issue(CH_PRINT, 8'hFF, 1'b0);
    issue(CH_CLOSE, 8'h00, 1'b1);
    issue(CH_RIGHT, 8'h00, 1'b1);
    issue(CH_LEFT, 8'h00, 1'b0);
    issue(CH_OPEN, 8'h00, 1'b0);
    issue(CH_CLOSE, 8'h00, 1'b0);
    issue(CH_READ, 8'h00, 1'b0);
    issue(CH_CLOSE, 8'h00, 1'b0);
    issue(CH_OPEN, 8'h00, 1'b0);
    issue(CH_OPEN, 8'h00, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_CLOSE, 8'h00, 1'b0);
    issue(CH_CLOSE, 8'h00, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_OPEN, 8'h00, 1'b0);
    issue(CH_END, 8'h00, 1'b0);
    pc = 16'hFFFF;
    issue(8'hFF, 8'hFF, 1'b1);
    issue(CH_END, 8'h00, 1'b0);

    // tape size extremes and a tape shrunk below the pointer
    set_tape_cells(16'd1);
    issue(CH_RIGHT, 8'h00, 1'b1);
    set_tape_cells(16'd0);
    issue(CH_RIGHT, 8'h00, 1'b1);
    issue(CH_PRINT, 8'h00, 1'b1);
    set_tape_cells(16'hFFFF);
    issue(CH_RIGHT, 8'h00, 1'b1);
    set_tape_cells(16'd32768);
    issue(CH_RIGHT, 8'h00, 1'b1);
    repeat (9) issue(CH_RIGHT, 8'h00, 1'b0);
    issue(CH_INC, 8'h00, 1'b0);
    set_tape_cells(16'd4);
    issue(CH_INC, 8'h00, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_LEFT, 8'h00, 1'b0);
    issue(CH_RIGHT, 8'h00, 1'b0);

    set_tape_cells(16'($urandom_range(2, 12)));
    run_random(350);
    set_tape_cells(16'($urandom_range(13, 64)));
    run_random(350);

    wait_idle();
    send_idle_pct = 75;
    recv_idle_pct = 27;
    set_tape_cells(16'hFFFF);
    run_random(350);
    set_tape_cells(16'($urandom_range(2, 32)));
    run_random(350);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // walk to the last cell of a small tape
    set_tape_cells(16'd64);
    issue(CH_RIGHT, 8'h00, 1'b1);
    repeat (64 - 2) issue(CH_RIGHT, 8'h00, 1'b0);
    issue(CH_READ, 8'h5A, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_RIGHT, 8'h00, 1'b0);
    // deep skip nesting closes on the matching bracket
    issue(CH_READ, 8'h00, 1'b1);
    issue(CH_OPEN, 8'h00, 1'b0);
    repeat (100) issue(CH_OPEN, 8'h00, 1'b0);
    repeat (100) issue(CH_CLOSE, 8'h00, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    issue(CH_CLOSE, 8'h00, 1'b0);
    issue(CH_PRINT, 8'h00, 1'b0);
    set_tape_cells(16'($urandom_range(1, 40)));
    run_random(300);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== brainfuck_execution_unit_top.f =====
src/bfe_pkg.sv
src/bfe_ifs.sv
src/bfe_ram.sv
src/brainfuck_execution_unit_top.sv
src/bfe_checker.sv
sim/bfe_exec_checker.sv
sim/brainfuck_execution_unit_top_tb.sv
